[hdl/crcfpb_pkg.sv]
// ----------------------------------------------------------------------------
// CRC-16 framed packet builder package
// Shared constants, item and job types, and the CRC-16/Modbus byte update.
// ----------------------------------------------------------------------------
package crcfpb_pkg;

	// Frame constants
	localparam logic [7:0]  HDR_FIRST       = 8'h55;
	localparam logic [7:0]  HDR_SECOND      = 8'hAA;
	localparam logic [7:0]  VERSION_RESET   = 8'h01;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [6:0]  MAX_PAYLOAD     = 7'd64;

	// Largest number of stream bytes that one input item produces
	localparam int          JOB_MAX         = 8;
	localparam int          JOB_CNT_W       = $clog2(JOB_MAX + 1);

	// Input item kinds, carried in tuser
	localparam logic        MODE_START      = 1'b0;
	localparam logic        MODE_PAYLOAD    = 1'b1;

	// One accepted input item
	typedef struct packed {
		logic       mode;
		logic [7:0] payload_byte;
		logic [7:0] message_type;
		logic [7:0] sequence_number;
		logic [6:0] frame_length;
	} item_t;

	// Bytes produced by one item; byte 0 goes out first
	typedef struct packed {
		logic [JOB_MAX-1:0][7:0] bytes;
		logic [JOB_CNT_W-1:0]    cnt;
		logic                    ends;
	} job_t;

	// CRC-16/Modbus update over one byte, reflected, LSB first
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[hdl/crcfpb_framer.sv]
// ----------------------------------------------------------------------------
// CRC-16 framed packet builder: frame tracker
// Holds the version register and the frame state, and turns each accepted
// item into the list of stream bytes it produces.
// ----------------------------------------------------------------------------
module crcfpb_framer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	input  logic               item_fire,
	input  crcfpb_pkg::item_t  item,
	output crcfpb_pkg::job_t   job
);
	import crcfpb_pkg::*;

	logic [7:0]  version_q;
	logic [15:0] running_crc_q;
	logic [6:0]  remaining_q;
	logic        frame_open_q;

	logic [15:0] crc_d;
	logic [6:0]  remaining_d;
	logic        frame_open_d;

	logic [6:0]  len_sat;
	logic [15:0] crc_hdr;
	logic [15:0] crc_pay;
	logic [6:0]  rem_dec;

	// Header CRC and payload CRC are both formed every cycle
	always_comb begin
		len_sat = (item.frame_length > MAX_PAYLOAD) ? MAX_PAYLOAD : item.frame_length;
		crc_hdr = crc_add(CRC_INIT, version_q);
		crc_hdr = crc_add(crc_hdr, item.message_type);
		crc_hdr = crc_add(crc_hdr, item.sequence_number);
		crc_hdr = crc_add(crc_hdr, {1'b0, len_sat});
		crc_pay = crc_add(running_crc_q, item.payload_byte);
		rem_dec = remaining_q - 7'd1;
	end

	// Job contents and next frame state
	always_comb begin
		job          = '0;
		crc_d        = running_crc_q;
		remaining_d  = remaining_q;
		frame_open_d = frame_open_q;
		if (item.mode == MODE_START) begin
			job.bytes[0] = HDR_FIRST;
			job.bytes[1] = HDR_SECOND;
			job.bytes[2] = version_q;
			job.bytes[3] = item.message_type;
			job.bytes[4] = item.sequence_number;
			job.bytes[5] = {1'b0, len_sat};
			if (len_sat == 7'd0) begin
				// Empty frame closes at once with its CRC
				job.bytes[6] = crc_hdr[7:0];
				job.bytes[7] = crc_hdr[15:8];
				job.cnt      = JOB_CNT_W'(8);
				job.ends     = 1'b1;
				crc_d        = CRC_INIT;
				remaining_d  = 7'd0;
				frame_open_d = 1'b0;
			end else begin
				job.cnt      = JOB_CNT_W'(6);
				crc_d        = crc_hdr;
				remaining_d  = len_sat;
				frame_open_d = 1'b1;
			end
		end else if (frame_open_q && (remaining_q != 7'd0)) begin
			job.bytes[0] = item.payload_byte;
			if (rem_dec == 7'd0) begin
				// Last payload byte is followed by the CRC
				job.bytes[1] = crc_pay[7:0];
				job.bytes[2] = crc_pay[15:8];
				job.cnt      = JOB_CNT_W'(3);
				job.ends     = 1'b1;
				crc_d        = CRC_INIT;
				remaining_d  = 7'd0;
				frame_open_d = 1'b0;
			end else begin
				job.cnt      = JOB_CNT_W'(1);
				crc_d        = crc_pay;
				remaining_d  = rem_dec;
			end
		end
	end

	// Version register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RESET;
		end else if (cfg_wr_en) begin
			version_q <= cfg_wr_data;
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= CRC_INIT;
			remaining_q   <= 7'd0;
			frame_open_q  <= 1'b0;
		end else if (item_fire) begin
			running_crc_q <= crc_d;
			remaining_q   <= remaining_d;
			frame_open_q  <= frame_open_d;
		end
	end

	// An open frame always has payload still to come
	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> (remaining_q != 7'd0))
		else $error("frame open with no payload left");

	// With no frame open the CRC sits at its initial value
	a_closed_crc_init: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> (running_crc_q == CRC_INIT))
		else $error("CRC not reset while no frame open");

	// A closing job always leaves the frame closed
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(item_fire && job.ends) |=> !frame_open_q)
		else $error("frame still open after its CRC");

endmodule

[hdl/crc16_framed_packet_builder.sv]
// ----------------------------------------------------------------------------
// CRC-16 framed packet builder
// Turns start and payload items into a framed byte stream with a
// CRC-16/Modbus trailer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         tuser: mode; tdata: payload_byte, message_type,
//                       sequence_number, frame_length
//  m_axis    out        tdata: out_byte; tlast: frame_end
//  cfg       in         version register write (cfg_wr_en, cfg_wr_data)
//
//  A mid-frame payload byte passes at one transfer per cycle while m_axis
//  does not stall. A start item holds the byte lane for its header (and CRC
//  for an empty frame), the last payload byte for itself and its CRC; the
//  single byte lane sets this. Bytes go via the job and output registers.
//  Reset clears the frame state and sets the version to 1; no clearing pass.
//  A stall on m_axis backs up into s_axis once the job register is busy.
// ----------------------------------------------------------------------------
module crc16_framed_packet_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] payload_byte, [15:8] message_type, [23:16] sequence_number,
	// [30:24] frame_length, [31] zero
	input  logic [31:0] s_axis_tdata,
	// [0] mode
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_byte
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast
);
	import crcfpb_pkg::*;

	item_t                item;
	job_t                 job;
	logic                 s_fire;
	logic                 out_adv;

	logic [JOB_MAX-1:0][7:0] job_bytes_q;
	logic [JOB_CNT_W-1:0]    job_cnt_q;
	logic                    job_ends_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	// Unpack the input transfer
	always_comb begin
		item.mode            = s_axis_tuser[0];
		item.payload_byte    = s_axis_tdata[7:0];
		item.message_type    = s_axis_tdata[15:8];
		item.sequence_number = s_axis_tdata[23:16];
		item.frame_length    = s_axis_tdata[30:24];
	end

	assign out_adv       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (job_cnt_q == '0) || ((job_cnt_q == JOB_CNT_W'(1)) && out_adv);
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	crcfpb_framer u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_fire   (s_fire),
		.item        (item),
		.job         (job)
	);

	// Job register: loaded on an input transfer, shifted as bytes go out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_cnt_q <= '0;
		end else if (s_fire) begin
			job_cnt_q <= job.cnt;
		end else if (out_adv && (job_cnt_q != '0)) begin
			job_cnt_q <= job_cnt_q - JOB_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			job_bytes_q <= job.bytes;
			job_ends_q  <= job.ends;
		end else if (out_adv && (job_cnt_q != '0)) begin
			job_bytes_q <= {8'h00, job_bytes_q[JOB_MAX-1:1]};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= (job_cnt_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && (job_cnt_q != '0)) begin
			out_byte_q <= job_bytes_q[0];
			out_last_q <= job_ends_q && (job_cnt_q == JOB_CNT_W'(1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	// The job count never exceeds the largest job
	a_job_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_cnt_q <= JOB_CNT_W'(JOB_MAX))
		else $error("job count out of range");

	// Pending job bytes keep the output register full
	a_job_feeds_out: assert property (@(posedge clk) disable iff (!arst_n)
		(job_cnt_q != '0) |=> m_axis_tvalid)
		else $error("output idle with job bytes pending");

	// A start transfer always loads at least a full header
	a_start_header: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (s_axis_tuser[0] == MODE_START)) |=> (job_cnt_q >= JOB_CNT_W'(6)))
		else $error("start transfer without header bytes");

endmodule
